// File: rtl/isrt_pkg.sv
package isrt_pkg;

  localparam int unsigned ValueWidth   = 32;
  localparam int unsigned DefaultDepth = 64;

  // One element of the set to sort.
  typedef struct packed {
    logic signed [ValueWidth-1:0] value;
    logic                         last;
  } isrt_in_t;

  // One element of the sorted run.
  typedef struct packed {
    logic signed [ValueWidth-1:0] sorted_value;
    logic                         last_out;
    logic                         overflow;
  } isrt_out_t;

  // Operation broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;  // place the broadcast value into the sorted row
    logic shl;  // move every value one cell toward the head
  } isrt_ctl_t;

endpackage

// File: rtl/insertion_sort_engine.sv
// Channel  Direction  Handshake                Payload
// item     in         start high, busy low     isrt_in_t  (value, last)
// result   out        result_valid, one cycle  isrt_out_t (sorted_value, last_out, overflow)
//
// While a set is loading, one transaction is accepted every cycle and placed in its cycle.
// The transaction with last set raises busy, which stays high while the n held elements (n <= DEPTH) go out.
// The row shifts one cell toward the head per busy cycle, and each shift loads the result.
// So n results come one per cycle, the first once busy and then the result register have loaded,
// and a new set can start in the cycle that carries the final result. The receiver can't stall.
// Synchronous reset empties the row and clears the overflow flag.
module insertion_sort_engine #(
  parameter int unsigned DEPTH = isrt_pkg::DefaultDepth
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  isrt_pkg::isrt_in_t  item,
  output logic                result_valid,
  output isrt_pkg::isrt_out_t result
);
  import isrt_pkg::*;

  localparam int unsigned CountWidth = $clog2(DEPTH + 1);

  // Element count and flag for the set being loaded or emitted.
  logic [CountWidth-1:0] count;
  logic [CountWidth-1:0] count_next;
  logic                  overflow_seen;
  logic                  overflow_seen_next;
  logic                  busy_next;

  logic                  accept;
  logic                  full;
  isrt_ctl_t             ctl;

  logic signed [ValueWidth-1:0] cell_value [DEPTH];
  logic                         cell_gt    [DEPTH];

  assign accept = start && !busy;
  assign full   = (count == CountWidth'(DEPTH));

  // A value that arrives while the row is full is dropped; the set is then
  // marked as overflowed for every result of its emit.
  assign ctl.ins = accept && !full;
  assign ctl.shl = busy;

  // The chain itself. Cell 0 holds the smallest value. During a load every cell
  // compares its value with the broadcast one; the insertion point is the first
  // cell whose value is greater, and everything from there on moves one cell to
  // the right. During an emit the row shifts toward cell 0 once per result.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [ValueWidth-1:0] left_value;
    logic                         left_gt;
    logic signed [ValueWidth-1:0] right_value;
    logic                         occupied;

    assign occupied = (CountWidth'(i) < count);

    if (i == 0) begin : g_head
      assign left_value = item.value;
      assign left_gt    = 1'b0;
    end else begin : g_body
      assign left_value = cell_value[i-1];
      assign left_gt    = cell_gt[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_value = cell_value[i];
    end else begin : g_inner
      assign right_value = cell_value[i+1];
    end

    isrt_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .occupied    (occupied),
      .bcast_value (item.value),
      .left_value  (left_value),
      .left_gt     (left_gt),
      .right_value (right_value),
      .value       (cell_value[i]),
      .gt          (cell_gt[i])
    );
  end

  always_comb begin
    count_next         = count;
    overflow_seen_next = overflow_seen;
    busy_next          = busy;
    if (busy) begin
      count_next = count - CountWidth'(1);
      if (count == CountWidth'(1)) begin
        busy_next          = 1'b0;
        overflow_seen_next = 1'b0;
      end
    end else if (accept) begin
      if (full) begin
        overflow_seen_next = 1'b1;
      end else begin
        count_next = count + CountWidth'(1);
      end
      busy_next = item.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      overflow_seen <= 1'b0;
      busy          <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      count         <= count_next;
      overflow_seen <= overflow_seen_next;
      busy          <= busy_next;
      result_valid  <= busy;
    end
  end

  // The result register takes the head of the row on each emit cycle.
  always_ff @(posedge clk) begin
    if (busy) begin
      result.sorted_value <= cell_value[0];
      result.last_out     <= (count == CountWidth'(1));
      result.overflow     <= overflow_seen;
    end
  end

`ifndef ASSERT_OFF
  // The emit ends only with the final result of the run.
  a_emit_ends_with_last : assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $fell(busy)) |-> (result_valid && result.last_out))
    else $error("emit ended without a final result");

  // A result transaction only follows an emit cycle.
  a_result_from_emit : assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result without emit");

  // A transaction marked last always starts an emit.
  a_last_starts_emit : assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.last) |=> busy)
    else $error("last transaction did not start emit");

  // The count never exceeds the row length, and an emit never runs empty.
  a_count_bounds : assert property (@(posedge clk) disable iff (rst)
    (count <= CountWidth'(DEPTH)) && (!busy || count != '0))
    else $error("element count out of range");
`endif

endmodule

// File: rtl/isrt_cell.sv
module isrt_cell (
  input  logic                                    clk,
  input  isrt_pkg::isrt_ctl_t                     ctl,
  input  logic                                    occupied,
  input  logic signed [isrt_pkg::ValueWidth-1:0]  bcast_value,
  input  logic signed [isrt_pkg::ValueWidth-1:0]  left_value,
  input  logic                                    left_gt,
  input  logic signed [isrt_pkg::ValueWidth-1:0]  right_value,
  output logic signed [isrt_pkg::ValueWidth-1:0]  value,
  output logic                                    gt
);
  import isrt_pkg::*;

  logic signed [ValueWidth-1:0] value_next;

  // A held value strictly greater than the new one moves right, which keeps
  // equal values in arrival order.
  assign gt = occupied && (value > bcast_value);

  always_comb begin
    value_next = value;
    if (ctl.ins) begin
      if (left_gt) begin
        value_next = left_value;
      end else if (gt || !occupied) begin
        value_next = bcast_value;
      end
    end else if (ctl.shl) begin
      value_next = right_value;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

// File: tb/sv/insertion_sort_checker.sv
module insertion_sort_checker #(
  parameter int unsigned DEPTH = isrt_pkg::DefaultDepth
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  isrt_pkg::isrt_in_t  item,
  input  logic                result_valid,
  input  isrt_pkg::isrt_out_t result,
  output int                  outstanding,
  output int                  failures
);

  import isrt_pkg::*;

  // Shadow of the sorted row and the drop flag of the set being loaded.
  logic signed [ValueWidth-1:0] held_row[$];
  logic                         drop_seen;
  isrt_out_t                    sorted_expected[$];
  int                           mismatch_count = 0;

  assign failures = mismatch_count;

  // Places a value after every held value that is less than or equal to it.
  task automatic place_value(input logic signed [ValueWidth-1:0] v);
    int pos;
    if (held_row.size() >= DEPTH) begin
      drop_seen = 1'b1;
      return;
    end
    pos = 0;
    while (pos < held_row.size() && !(held_row[pos] > v)) pos++;
    held_row.insert(pos, v);
  endtask

  task automatic emit_sorted_run();
    isrt_out_t r;
    for (int k = 0; k < held_row.size(); k++) begin
      r.sorted_value = held_row[k];
      r.last_out     = (k == held_row.size() - 1);
      r.overflow     = drop_seen;
      sorted_expected.push_back(r);
    end
    held_row.delete();
    drop_seen = 1'b0;
  endtask

  always @(posedge clk) begin
    isrt_out_t want;
    if (rst) begin
      held_row.delete();
      sorted_expected.delete();
      drop_seen = 1'b0;
    end else begin
      if (result_valid) begin
        if (sorted_expected.size() == 0) begin
          $error("unexpected result: sorted_value %0d", result.sorted_value);
          mismatch_count++;
        end else begin
          want = sorted_expected.pop_front();
          if (result.sorted_value !== want.sorted_value) begin
            $error("sorted_value: expected %0d, got %0d", want.sorted_value,
                   result.sorted_value);
            mismatch_count++;
          end
          if (result.last_out !== want.last_out) begin
            $error("last_out: expected %0b, got %0b", want.last_out, result.last_out);
            mismatch_count++;
          end
          if (result.overflow !== want.overflow) begin
            $error("overflow: expected %0b, got %0b", want.overflow, result.overflow);
            mismatch_count++;
          end
        end
      end
      if (start && !busy) begin
        place_value(item.value);
        if (item.last) emit_sorted_run();
      end
    end
    outstanding <= sorted_expected.size();
  end

endmodule

// File: tb/sv/insertion_sort_engine_tb.sv
module insertion_sort_engine_tb;

  import isrt_pkg::*;

  localparam int unsigned Depth = DefaultDepth;

  // Every input is known from time zero; reset is held high from the start.
  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  isrt_in_t  item = '0;
  logic      busy;
  logic      result_valid;
  isrt_out_t result;
  int        outstanding;
  int        failures;

  // Percentage of cycles in which the sender holds start low before a transaction.
  int        idle_pct = 17;

  always #5 clk = ~clk;

  insertion_sort_engine #(
    .DEPTH(Depth)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .item        (item),
    .result_valid(result_valid),
    .result      (result)
  );

  // The checker sees the same pins as the block, keeps its own sorted row and
  // compares every result strobe against the oldest predicted element.
  insertion_sort_checker #(
    .DEPTH(Depth)
  ) u_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .item        (item),
    .result_valid(result_valid),
    .result      (result),
    .outstanding (outstanding),
    .failures    (failures)
  );

  // Values lean toward the two extremes and a narrow band around zero, so that
  // equal values and sign crossings show up often inside one set.
  function automatic logic signed [ValueWidth-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return {1'b1, {(ValueWidth-1){1'b0}}};
      1:       return {1'b0, {(ValueWidth-1){1'b1}}};
      2, 3, 4: return $signed($urandom_range(0, 8)) - 4;
      default: return $urandom;
    endcase
  endfunction

  // Presents one transaction and returns at the edge that accepts it. Between
  // transactions start stays high unless the sender chooses to idle, so start
  // never gets two assignments in one time step.
  task automatic send_item(input logic signed [ValueWidth-1:0] v, input logic is_last);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    item  <= '{value: v, last: is_last};
    @(posedge clk);
    // A transaction is taken only at an edge where busy was low.
    while (busy) @(posedge clk);
  endtask

  task automatic send_set(input int n);
    for (int i = 0; i < n; i++) send_item(pick_value(), i == n - 1);
  endtask

  // Holds the sender off until the checker has seen every predicted result.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin
    logic signed [ValueWidth-1:0] mixed[10];
    int sent;
    int set_idx;
    int big_size;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed sets: one-element sets at each extreme and at zero, then a mixed
    // set with repeats and both extremes, then a strictly descending set that
    // forces every insertion to the head of the row.
    send_item({1'b0, {(ValueWidth-1){1'b1}}}, 1'b1);
    send_item({1'b1, {(ValueWidth-1){1'b0}}}, 1'b1);
    send_item('0, 1'b1);
    mixed = '{5, -3, 5, 32'sh7fffffff, 32'sh80000000, -1, 0, 1, -3, 5};
    foreach (mixed[i]) send_item(mixed[i], i == 9);
    for (int i = 4; i >= 0; i--) send_item(i, i == 0);

    // Random sets in three idling regimes. Each regime carries one large set:
    // a set that exactly fills the row, one whose final element is dropped,
    // and one that drops ordinary elements as well as the final one.
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 17 : (ph == 1) ? 67 : 0;
      big_size = (ph == 0) ? Depth : (ph == 1) ? Depth + 1 : Depth + 3;
      // Before the last regime the sender waits out a whole emit with no
      // transaction pending.
      if (ph == 2) drain();
      sent = 0;
      set_idx = 0;
      while (sent < 80) begin
        int n;
        if (set_idx == 2) n = big_size;
        else if ($urandom_range(0, 5) == 0) n = $urandom_range(9, 20);
        else n = $urandom_range(1, 8);
        send_set(n);
        sent += n;
        set_idx++;
      end
    end

    // Wait for the last run to come out, then keep watching the idle outputs to catch
    // any stray strobe.
    drain();
    repeat (Depth + 8) @(posedge clk);
    @(negedge clk);
    if (failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #3000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// File: files.f
rtl/isrt_pkg.sv
rtl/isrt_cell.sv
rtl/insertion_sort_engine.sv
tb/sv/insertion_sort_checker.sv
tb/sv/insertion_sort_engine_tb.sv
